// File: design/int_to_decimal_ascii_assert.svh
// Assertion macros used by the top-level RTL of the decimal text converter.
// ITDA_ASSERT is gated by reset; ITDA_ASSERT_ALWAYS is also checked while reset is applied.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef ASSERT_OFF
`define ITDA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("itda assertion failed");
`define ITDA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("itda assertion failed");
`else
`define ITDA_ASSERT(lbl, clk, rst_n, prop)
`define ITDA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: design/itda_pkg.sv
`default_nettype none

package itda_pkg;

	// Valid bit and sign of one item as it moves down the pipeline.
	typedef struct packed {
		logic vld;
		logic neg;
	} ctl_t;

	// Binary bits folded into the BCD digits by each conversion stage.
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [3:0] ADJ_LIMIT = 4'd5;
	localparam logic [3:0] ADJ_ADD = 4'd3;

	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] MINUS_CHAR = 8'd45;

endpackage

`default_nettype wire

// File: design/itda_sign.sv
`default_nettype none

// First stage: takes the absolute value and remembers the sign.
module itda_sign #(
	parameter int VALUE_WIDTH = 32,
	parameter int BW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          take,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output itda_pkg::ctl_t                ctl,
	output logic [BW-1:0]                 bin
);

	logic                   vld_s1;
	logic                   neg_s1;
	logic [BW-1:0]          bin_s1;
	logic [VALUE_WIDTH-1:0] mag;

	// The most negative value wraps to itself, which read unsigned is its magnitude.
	assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= value[VALUE_WIDTH-1];
			bin_s1 <= BW'(mag);
		end
	end

	assign ctl.vld = vld_s1;
	assign ctl.neg = neg_s1;
	assign bin = bin_s1;

endmodule

`default_nettype wire

// File: design/itda_dabble.sv
`default_nettype none

// One shift-and-add-3 conversion stage; the _sn registers are this stage's output.
module itda_dabble #(
	parameter int NB = 40,
	parameter int BW = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  itda_pkg::ctl_t prev_ctl,
	input  logic [NB-1:0]  prev_bcd,
	input  logic [BW-1:0]  prev_bin,
	output itda_pkg::ctl_t ctl,
	output logic [NB-1:0]  bcd,
	output logic [BW-1:0]  bin
);

	localparam int NDIG = NB / 4;

	logic          vld_sn;
	logic          neg_sn;
	logic [NB-1:0] bcd_sn;
	logic [BW-1:0] bin_sn;
	logic [NB-1:0] b;
	logic [BW-1:0] m;

	always_comb begin
		b = prev_bcd;
		m = prev_bin;
		for (int s = 0; s < itda_pkg::STEPS_PER_STAGE; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (b[4*d +: 4] >= itda_pkg::ADJ_LIMIT) begin
					b[4*d +: 4] = b[4*d +: 4] + itda_pkg::ADJ_ADD;
				end
			end
			{b, m} = {b, m} << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_sn <= prev_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sn <= prev_ctl.neg;
			bcd_sn <= b;
			bin_sn <= m;
		end
	end

	assign ctl.vld = vld_sn;
	assign ctl.neg = neg_sn;
	assign bcd = bcd_sn;
	assign bin = bin_sn;

endmodule

`default_nettype wire

// File: design/itda_align.sv
`default_nettype none

// Counts the significant digits and moves the leading one to the top.
module itda_align #(
	parameter int NB = 40,
	parameter int CW = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  itda_pkg::ctl_t prev_ctl,
	input  logic [NB-1:0]  prev_bcd,
	output itda_pkg::ctl_t ctl,
	output logic [NB-1:0]  digits,
	output logic [CW-1:0]  count
);

	localparam int NDIG = NB / 4;

	logic          vld_sn;
	logic          neg_sn;
	logic [NB-1:0] dig_sn;
	logic [CW-1:0] cnt_sn;
	logic [CW-1:0] nd;
	logic [CW-1:0] sh;

	// Zero still shows one digit.
	always_comb begin
		nd = CW'(1);
		for (int d = 1; d < NDIG; d++) begin
			if (prev_bcd[4*d +: 4] != 4'd0) begin
				nd = CW'(d + 1);
			end
		end
		sh = CW'(NDIG) - nd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_sn <= prev_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sn <= prev_ctl.neg;
			dig_sn <= prev_bcd << {sh, 2'b00};
			cnt_sn <= nd;
		end
	end

	assign ctl.vld = vld_sn;
	assign ctl.neg = neg_sn;
	assign digits = dig_sn;
	assign count = cnt_sn;

endmodule

`default_nettype wire

// File: design/itda_emit.sv
`default_nettype none

// Sends the sign and the digits of one item, one character per cycle.
module itda_emit #(
	parameter int NB = 40,
	parameter int CW = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  itda_pkg::ctl_t ctl,
	input  logic [NB-1:0]  digits,
	input  logic [CW-1:0]  count,
	output logic           ready,
	output logic [7:0]     character,
	output logic           last,
	output logic           strobe
);

	logic          act_q;
	logic          minus_q;
	logic [NB-1:0] dig_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic          strobe_q;
	logic          final_digit;
	logic          load;

	assign final_digit = !minus_q && (cnt_q == CW'(1));
	assign ready = !act_q || final_digit;
	assign load = ctl.vld && ready;

	// A new item is only taken while idle or on the final digit, when the minus flag is
	// already clear, so loading takes priority over ending the current run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			minus_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (load) begin
				act_q   <= 1'b1;
				minus_q <= ctl.neg;
			end else if (act_q) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (final_digit) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_q) begin
			if (minus_q) begin
				char_q <= itda_pkg::MINUS_CHAR;
				last_q <= 1'b0;
			end else begin
				char_q <= itda_pkg::DIGIT_BASE + {4'b0000, dig_q[NB-1 -: 4]};
				last_q <= final_digit;
			end
		end
		if (load) begin
			dig_q <= digits;
			cnt_q <= count;
		end else if (act_q && !minus_q) begin
			dig_q <= dig_q << 4;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign character = char_q;
	assign last = last_q;
	assign strobe = strobe_q;

endmodule

`default_nettype wire

// File: design/int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// A command is taken at a rising edge where start is high and busy is low; value is the
// two's complement integer to convert. Its text comes back on character, one byte per
// cycle, each beat marked by strobe for exactly one cycle, most significant first: a
// minus sign for a negative value, then the digits without leading zeros. Zero gives a
// lone '0', the most negative value gives its full magnitude. last is high on the final
// beat of each run; no terminator follows.
// The first beat follows the command through the sign stage, the NSTG conversion
// stages, where NSTG is VALUE_WIDTH / 8 rounded up, the align stage and the emitter.
// A run holds 1 to 11 characters at 32 bits.
// Throughput: one command per cycle enters the pipeline while busy is low, but the
// emitter sends one beat per cycle, so it sets the sustained rate: one item per run
// length, at most 11 characters at 32 bits. When the last stage holds an item that the
// emitter cannot yet take, the whole pipeline holds and busy is raised until it frees up.
// The receiver cannot stall; every beat must be taken as it is shown.
// Reset clears all valid bits and the emitter; anything in flight is dropped.
`default_nettype none

module int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          busy,
	output logic [7:0]                    character,
	output logic                          last,
	output logic                          strobe
);

`include "int_to_decimal_ascii_assert.svh"

	// Digits needed for the largest magnitude, two to the power VALUE_WIDTH - 1.
	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int NB = NDIG * 4;
	localparam int CW = $clog2(NDIG + 1);
	// Conversion stages; the binary word is padded at the top to a whole number of them,
	// and the leading zero bits shifted in first do not change the result.
	localparam int NSTG = (VALUE_WIDTH + itda_pkg::STEPS_PER_STAGE - 1)
		/ itda_pkg::STEPS_PER_STAGE;
	localparam int BW = NSTG * itda_pkg::STEPS_PER_STAGE;

	// The whole pipeline advances together; it holds only when the aligned item at its
	// end cannot be handed to the emitter.
	logic           en;
	logic           ready;
	itda_pkg::ctl_t ctl_w [NSTG+1];
	logic [NB-1:0]  bcd_w [NSTG+1];
	logic [BW-1:0]  bin_w [NSTG+1];
	itda_pkg::ctl_t ctl_a;
	logic [NB-1:0]  dig_a;
	logic [CW-1:0]  cnt_a;

	assign en = !(ctl_a.vld && !ready);
	assign busy = !en;

	// Stage one: sign and magnitude.
	itda_sign #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.BW(BW)
	) u_sign (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.take(start),
		.value(value),
		.ctl(ctl_w[0]),
		.bin(bin_w[0])
	);

	assign bcd_w[0] = '0;

	// Binary to BCD, eight bits per stage.
	for (genvar g = 0; g < NSTG; g++) begin : g_dabble
		itda_dabble #(
			.NB(NB),
			.BW(BW)
		) u_dabble (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev_ctl(ctl_w[g]),
			.prev_bcd(bcd_w[g]),
			.prev_bin(bin_w[g]),
			.ctl(ctl_w[g+1]),
			.bcd(bcd_w[g+1]),
			.bin(bin_w[g+1])
		);
	end

	// Leading zero removal: the most significant digit is moved to the top nibble.
	itda_align #(
		.NB(NB),
		.CW(CW)
	) u_align (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.prev_ctl(ctl_w[NSTG]),
		.prev_bcd(bcd_w[NSTG]),
		.ctl(ctl_a),
		.digits(dig_a),
		.count(cnt_a)
	);

	// Character emitter with registered outputs. It can take the next item in the cycle
	// that registers the last digit of the current one, so runs follow without a gap.
	itda_emit #(
		.NB(NB),
		.CW(CW)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_a),
		.digits(dig_a),
		.count(cnt_a),
		.ready(ready),
		.character(character),
		.last(last),
		.strobe(strobe)
	);

	// A run, once started, sends a beat in every cycle until its last one.
	`ITDA_ASSERT(a_run_contiguous, clk, arst_n, (strobe && !last) |=> strobe)
	// A minus sign is always followed by at least one digit.
	`ITDA_ASSERT(a_minus_not_last, clk, arst_n,
		(strobe && character == itda_pkg::MINUS_CHAR) |-> !last)
	// Every binary bit has been folded into the digits by the end of the conversion.
	`ITDA_ASSERT(a_bin_consumed, clk, arst_n, ctl_w[NSTG].vld |-> bin_w[NSTG] == '0)
	// Under reset nothing is sent and commands are not held off.
	`ITDA_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!strobe && !busy))

endmodule

`default_nettype wire
